FILE: sv/ptt_pkg.sv
package ptt_pkg;

  // Table size and derived widths
  localparam int TIMERS = 8;
  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int SLOT_W = 6;
  localparam int TICK_W = 32;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_POLL = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_POLL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } back_state_t;

  typedef struct packed {
    func_t              func;
    logic [TICK_W-1:0]  interval;
    logic               enable;
    logic [TICK_W-1:0]  start_tick;
  } cmd_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [SLOT_W-1:0]  slot;
    logic [TICK_W-1:0]  now_tick;
    logic               last;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [TICK_W-1:0]  interval;
    logic               enable;
    logic [TICK_W-1:0]  start_tick;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

FILE: sv/ptt_front.sv
module ptt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ptt_pkg::cmd_t        cmd,
  input  logic                 pop,
  output ptt_pkg::queue_head_t head
);
  import ptt_pkg::*;

  queue_entry_t        q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                do_pop;
  queue_entry_t        entry_in;

  assign busy = (count == QCNT_W'(QDEPTH));

  // Classify: unused function code is accepted and dropped here
  always_comb begin
    entry_in.interval   = cmd.interval;
    entry_in.enable     = cmd.enable;
    entry_in.start_tick = cmd.start_tick;
    push                = start && !busy;
    unique case (cmd.func)
      FUNC_ADD:  entry_in.op = OP_ADD;
      FUNC_TICK: entry_in.op = OP_TICK;
      FUNC_POLL: entry_in.op = OP_POLL;
      default: begin
        entry_in.op = OP_TICK;
        push        = 1'b0;
      end
    endcase
  end

  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry_in;
    end
  end

endmodule

FILE: sv/ptt_back.sv
module ptt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ptt_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 strobe,
  output ptt_pkg::result_t     result
);
  import ptt_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  logic [TICK_W-1:0]   tick_count;
  logic [TIMERS-1:0]   occupied;
  logic [TIMERS-1:0]   enabled;
  logic [TICK_W-1:0]   interval [TIMERS];
  logic [TICK_W-1:0]   previous [TIMERS];
  logic [IDX_W-1:0]    idx;
  logic                have_pend;
  logic [IDX_W-1:0]    pend_slot;

  logic                any_free;
  logic [IDX_W-1:0]    free_idx;
  logic [TICK_W-1:0]   elapsed;
  logic                hit;
  logic                idx_last;
  logic                do_add;
  logic                do_tick;
  logic                do_poll;
  logic                res_valid_next;
  result_t             result_next;

  // Lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign elapsed  = tick_count - previous[idx];
  assign hit      = (state == BK_SCAN) && occupied[idx] && enabled[idx] &&
                    (elapsed >= interval[idx]);
  assign idx_last = (idx == IDX_W'(TIMERS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head.valid && head.entry.op == OP_POLL) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (idx_last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop                     = 1'b0;
    do_add                  = 1'b0;
    do_tick                 = 1'b0;
    do_poll                 = 1'b0;
    res_valid_next          = 1'b0;
    result_next.result_kind = KIND_NONE;
    result_next.slot        = '0;
    result_next.now_tick    = tick_count;
    result_next.last        = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.entry.op)
            OP_ADD: begin
              do_add                  = any_free;
              res_valid_next          = 1'b1;
              result_next.result_kind = any_free ? KIND_ADDED : KIND_FULL;
              result_next.slot        = any_free ? SLOT_W'(free_idx) : '0;
            end
            OP_TICK: do_tick = 1'b1;
            OP_POLL: do_poll = 1'b1;
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        // a new hit releases the one held back, which is then known not last
        if (hit && have_pend) begin
          res_valid_next          = 1'b1;
          result_next.result_kind = KIND_FIRED;
          result_next.slot        = SLOT_W'(pend_slot);
          result_next.last        = 1'b0;
        end
      end
      BK_DONE: begin
        res_valid_next = 1'b1;
        if (have_pend) begin
          result_next.result_kind = KIND_FIRED;
          result_next.slot        = SLOT_W'(pend_slot);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      tick_count <= '0;
      occupied   <= '0;
      strobe     <= 1'b0;
      have_pend  <= 1'b0;
      idx        <= '0;
    end else begin
      state  <= state_next;
      strobe <= res_valid_next;
      if (do_add) begin
        occupied[free_idx] <= 1'b1;
      end
      if (do_tick) begin
        tick_count <= tick_count + 1'b1;
      end
      if (do_poll) begin
        idx       <= '0;
        have_pend <= 1'b0;
      end else if (state == BK_SCAN) begin
        idx <= idx_last ? '0 : idx + 1'b1;
        if (hit) begin
          have_pend <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (do_add) begin
      interval[free_idx] <= head.entry.interval;
      enabled[free_idx]  <= head.entry.enable;
      previous[free_idx] <= head.entry.start_tick;
    end
    if (hit) begin
      previous[idx] <= tick_count;
      pend_slot     <= idx;
    end
  end

endmodule

FILE: sv/periodic_timer_table.sv
// Channel    Ports                   Handshake
// request    start, busy, cmd        taken on start && !busy
// result     strobe, result          one cycle, receiver cannot stall
//
// An add or tick is done in the back end's idle state once it reaches the queue head.
// A poll runs in order: a start in the idle state, a scan state that visits each slot,
// then a done state that delivers the final result. The per-slot scan sets the rate.
// Results appear on the cycle after they are produced (output register).
// Reset (rst, synchronous) empties the queue, clears the tick counter and
// marks every slot free. busy rises only while the command queue is full.
module periodic_timer_table_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptt_pkg::cmd_t     cmd,
  output logic              strobe,
  output ptt_pkg::result_t  result
);
  import ptt_pkg::*;

  queue_head_t head;
  logic        pop;

  // Front end: accepts requests, drops unused codes, queues the rest
  ptt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .pop   (pop),
    .head  (head)
  );

  // Back end: owns the tick counter and slot table, runs adds, ticks, polls.
  // Poll fires are held back one hit so the final one can carry last.
  ptt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

  // Full and none results carry slot zero and close their request
  a_full_none_form: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind == KIND_FULL || result.result_kind == KIND_NONE)
    |-> (result.slot == '0) && result.last)
    else $error("full/none result malformed");

  // An add result always closes its request
  a_add_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind == KIND_ADDED) |-> result.last)
    else $error("add result without last");

  // Fired slots lie inside the table
  a_fire_slot: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind == KIND_FIRED)
    |-> ({1'b0, result.slot} < (SLOT_W + 1)'(TIMERS)))
    else $error("fired slot out of range");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe after reset");

endmodule

FILE: verif/periodic_timer_table_core_tb.sv
module periodic_timer_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  // Longest stretch with neither a request nor a result taken before the run is
  // called hung. A poll scans every slot and the queue holds two requests, so
  // real stalls stay far below this limit. Sender gaps are geometric.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settle time after the last result: a trailing tick may still sit in the
  // queue, and a stray result would show up within a poll time.
  localparam int TAIL_CYCLES = 2 * TIMERS + 8;
  localparam int RANDOM_PER_PHASE = 116;

  // Shadow copy of the timer table. It applies each accepted request and lines
  // up the results that request must produce, then checks the block against them.
  class timer_table_shadow;
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] period [TIMERS];
    logic [TICK_W-1:0] last_fire [TIMERS];
    bit                armed [TIMERS];
    bit                in_use [TIMERS];
    result_t           due_results[$];
    int                errors;

    function new();
      tick_now = '0;
      for (int i = 0; i < TIMERS; i++) begin
        period[i] = '0;
        last_fire[i] = '0;
        armed[i] = 1'b0;
        in_use[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function result_t make_result(kind_t kind, int slot_idx, logic final_flag);
      result_t r;
      r.result_kind = kind;
      r.slot = SLOT_W'(slot_idx);
      r.now_tick = tick_now;
      r.last = final_flag;
      return r;
    endfunction

    function void apply_request(cmd_t c);
      result_t           fired[$];
      logic [TICK_W-1:0] elapsed;
      int                free_slot;
      free_slot = -1;
      case (c.func)
        FUNC_ADD: begin
          for (int i = 0; i < TIMERS; i++)
            if (!in_use[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            due_results.push_back(make_result(KIND_FULL, 0, 1'b1));
          end else begin
            in_use[free_slot] = 1'b1;
            period[free_slot] = c.interval;
            armed[free_slot] = c.enable;
            last_fire[free_slot] = c.start_tick;
            due_results.push_back(make_result(KIND_ADDED, free_slot, 1'b1));
          end
        end
        FUNC_TICK: tick_now = tick_now + 1'b1;
        FUNC_POLL: begin
          for (int i = 0; i < TIMERS; i++) begin
            if (in_use[i] && armed[i]) begin
              elapsed = tick_now - last_fire[i];
              if (elapsed >= period[i]) begin
                last_fire[i] = tick_now;
                fired.push_back(make_result(KIND_FIRED, i, 1'b0));
              end
            end
          end
          if (fired.size() == 0) begin
            due_results.push_back(make_result(KIND_NONE, 0, 1'b1));
          end else begin
            fired[fired.size() - 1].last = 1'b1;
            foreach (fired[j]) due_results.push_back(fired[j]);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d tick %0d last %0d",
                                  got.result_kind, got.slot, got.now_tick, got.last));
        return;
      end
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch($sformatf("result_kind got %0d want %0d",
                                  got.result_kind, want.result_kind));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
      if (got.now_tick !== want.now_tick)
        report_mismatch($sformatf("now_tick got %0h want %0h", got.now_tick, want.now_tick));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
    endtask

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    strobe;
  result_t result;

  timer_table_shadow shadow;
  int stall_cycles = 0;

  periodic_timer_table_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Everything is sampled at the rising edge, before the block's own updates land.
  // Results are checked before the request of the same edge is applied: a result
  // never belongs to a request taken on that very edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) shadow.check_result(result);
      if (start && !busy) shadow.apply_request(cmd);
    end
  end

  // Hang detector: counts edges at which neither side moved anything.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(func_t f, logic [TICK_W-1:0] iv, logic en,
                                    logic [TICK_W-1:0] st);
    cmd_t c;
    c.func = f;
    c.interval = iv;
    c.enable = en;
    c.start_tick = st;
    return c;
  endfunction

  function automatic cmd_t random_fields();
    return make_cmd(func_t'($urandom_range(3)), $urandom(), 1'($urandom_range(1)),
                    $urandom());
  endfunction

  // Mix leans on ticks and polls so timers keep coming due. Adds always hit a
  // full table once the directed part has filled it; their fields stay random.
  function automatic cmd_t random_request();
    cmd_t c;
    int   pick;
    c = random_fields();
    pick = $urandom_range(99);
    if (pick < 45) begin
      c.func = FUNC_TICK;
    end else if (pick < 80) begin
      c.func = FUNC_POLL;
    end else if (pick < 95) begin
      c.func = FUNC_ADD;
      if ($urandom_range(1)) c.interval = $urandom_range(20);
      if ($urandom_range(1)) c.start_tick = shadow.tick_now - $urandom_range(8);
    end else begin
      c.func = FUNC_NOP;
    end
    return c;
  endfunction

  // Holds the request on the bus until the block takes it, returns at a falling edge.
  task automatic send_request(cmd_t c);
    start = 1'b1;
    cmd = c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Sender gaps: each cycle idles with the given odds, junk on the request bus.
  task automatic idle_for(int pct);
    while ($urandom_range(99) < pct) begin
      start = 1'b0;
      cmd = random_fields();
      @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain();
    start = 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    int   phase_idle[4];
    int   sent;
    cmd_t c;
    phase_idle[0] = 0;
    phase_idle[1] = 59;
    phase_idle[2] = 0;
    phase_idle[3] = 28;
    shadow = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, tick counter starts at zero.
    // Poll on an empty table: single none result.
    send_request(make_cmd(FUNC_POLL, '0, 1'b0, '0));
    // Zero interval: fires on every poll.
    send_request(make_cmd(FUNC_ADD, '0, 1'b1, '0));
    send_request(make_cmd(FUNC_POLL, '1, 1'b1, '1));
    // Disabled timer holds its slot and stays quiet.
    send_request(make_cmd(FUNC_ADD, '0, 1'b0, '1));
    // Max interval, previous one ahead of now: elapsed wraps to all ones and fires once.
    send_request(make_cmd(FUNC_ADD, '1, 1'b1, 32'd1));
    // Previous tick before the wrap point: fires after the counter reaches 1.
    send_request(make_cmd(FUNC_ADD, 32'd3, 1'b1, 32'hFFFF_FFFE));
    send_request(make_cmd(FUNC_POLL, '0, 1'b0, '0));
    send_request(make_cmd(FUNC_TICK, '1, 1'b1, '1));
    send_request(make_cmd(FUNC_POLL, '0, 1'b0, '0));
    send_request(make_cmd(FUNC_ADD, 32'd2, 1'b1, '0));
    send_request(make_cmd(FUNC_ADD, 32'd5, 1'b1, 32'h8000_0000));
    send_request(make_cmd(FUNC_ADD, 32'd1, 1'b1, 32'd1));
    send_request(make_cmd(FUNC_ADD, 32'hFFFF_FFFE, 1'b1, 32'hAAAA_AAAA));
    // Table is full now.
    send_request(make_cmd(FUNC_ADD, '1, 1'b1, '1));
    // Unused code: swallowed with no result.
    send_request(make_cmd(FUNC_NOP, '1, 1'b1, '1));
    send_request(make_cmd(FUNC_NOP, '0, 1'b0, '0));
    send_request(make_cmd(FUNC_TICK, '0, 1'b0, '0));
    send_request(make_cmd(FUNC_TICK, 32'h5555_5555, 1'b0, 32'h5555_5555));
    send_request(make_cmd(FUNC_POLL, '0, 1'b0, '0));
    // Back-to-back poll: only the zero-interval timer is due.
    send_request(make_cmd(FUNC_POLL, '0, 1'b0, '0));
    drain();

    // Random phases, each ending with a full drain.
    foreach (phase_idle[p]) begin
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        idle_for(phase_idle[p]);
        c = random_request();
        send_request(c);
        if (c.func != FUNC_NOP) sent++;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (shadow.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
